/* rtl/core/wpvt_pkg.sv */
// Shared types and codes for the windowed pose velocity tracker.
`default_nettype none
package wpvt_pkg;

   // Operation codes carried in req_tuser
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Status codes carried in rsp_tuser
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_SPAN  = 2'd2;
   localparam logic [1:0] ST_CLEAR = 2'd3;

   // Configuration register indexes
   localparam logic REG_MAX_HISTORY = 1'b0;
   localparam logic REG_WINDOW_US   = 1'b1;

   // Register reset values
   localparam logic [6:0]  MAX_HISTORY_RESET = 7'd64;
   localparam logic [23:0] WINDOW_US_RESET   = 24'd1000000;

   // Microseconds per second, scale of the velocity numerator
   localparam logic [19:0] US_PER_S = 20'd1000000;

   // Numerator width: 33-bit magnitude times a 20-bit scale
   localparam int NUM_W = 53;

   // One stored pose
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic        [47:0] t;
   } pose_type;

   // Shift control shared by every history cell
   typedef struct packed {
      logic push;    // take the neighbor on the newer side
      logic rotate;  // take the neighbor on the older side
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* rtl/core/wpvt_cell.sv */
// One history cell: holds a pose and shifts it along the chain.
`default_nettype none
module wpvt_cell (
   input  wire logic                   clock,
   input  wire wpvt_pkg::cell_ctrl_type ctrl,
   input  wire wpvt_pkg::pose_type     newer_in,
   input  wire wpvt_pkg::pose_type     older_in,
   output wpvt_pkg::pose_type          pose_out
);
   import wpvt_pkg::*;

   pose_type pose_ff;
   pose_type pose_in;

   // Push moves entries toward the old end, rotate toward the new end
   always_comb begin
      pose_in = pose_ff;
      if (ctrl.push) begin
         pose_in = newer_in;
      end else if (ctrl.rotate) begin
         pose_in = older_in;
      end
   end

   always_ff @(posedge clock) begin
      pose_ff <= pose_in;
   end

   assign pose_out = pose_ff;
endmodule
`default_nettype wire

/* rtl/core/wpvt_vel_lane.sv */
// Velocity lane: scales a position difference and divides by the span, one bit a cycle.
`default_nettype none
module wpvt_vel_lane (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [32:0] diff,
   input  wire logic        [47:0] span,
   output logic signed [31:0]      vel,
   output logic                    done
);
   import wpvt_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [48:0]      rem_ff, rem_in;
   logic [47:0]      span_ff, span_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [32:0] mag;
   logic [49:0] trial;
   logic        fits;

   assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {2'b00, span_ff};

   // Restoring division, numerator bits enter from the top
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      span_in = span_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = NUM_W'(mag * US_PER_S);
         quo_in  = '0;
         rem_in  = '0;
         span_in = span;
         neg_in  = diff[32];
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? 49'(trial - {2'b00, span_ff}) : trial[48:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
      neg_ff  <= neg_in;
   end

   // Truncated quotient with sign, saturated to 32 bits
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > NUM_W'(33'h080000000)) begin
            vel = 32'sh80000000;
         end else begin
            vel = 32'(-quo_ff[31:0]);
         end
      end else begin
         if (quo_ff > NUM_W'(32'h7FFFFFFF)) begin
            vel = 32'sh7FFFFFFF;
         end else begin
            vel = quo_ff[31:0];
         end
      end
   end

   assign done = done_ff;
endmodule
`default_nettype wire

/* rtl/core/wpvt_isqrt.sv */
// Integer square root of a 64-bit value, one result bit a cycle, saturated to 32 bits.
`default_nettype none
module wpvt_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic [31:0]      root,
   output logic             done
);
   logic [63:0] n_ff, n_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   // Partial root sits shifted up to the current bit, so it needs the full width
   assign trial = root_ff + bit_ff;

   // Classic digit-by-digit root, the bit walks down two places per step
   always_comb begin
      n_in    = n_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         n_in    = value;
         root_in = '0;
         bit_in  = 64'h4000000000000000;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in    = n_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff    <= n_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign root = (root_ff[63:32] != 32'd0) ? 32'hFFFFFFFF : root_ff[31:0];
   assign done = done_ff;
endmodule
`default_nettype wire

/* rtl/core/windowed_pose_velocity_tracker.sv */
// Top level of the windowed pose velocity tracker.
//
// Input channel req_*: one transaction is a push (req_tuser = 0) of a timestamped
// position, or a clear (req_tuser = 1) of the oldest entries. Every input
// transaction yields exactly one result transaction on rsp_*, with status in
// rsp_tuser. Registers max_history (index 0) and window_us (index 1) are written
// through csr_*, always ready, by the user only while the block is idle, unchecked.
// History lives in a chain of HISTORY_DEPTH cells, newest in cell 0. A push
// shifts the chain by one in the accept cycle. The velocity search then
// rotates the whole ring once, testing the entry passing cell 1 each cycle;
// the rotation restores the original order.
// Path per item: an empty history or a rejected clear goes from the latch
// straight to the result; otherwise the search runs, and if no start entry
// qualifies the result follows it. With a velocity the search is followed by
// divider lanes (three in parallel, 53 steps each), squaring of the three
// components on one multiplier and a square root (32 steps).
// One item is processed at a time; req_tready is high only between items.
// A finished result sits in the output register until taken; while the
// receiver stalls a second result waits in the sequencer.
// Reset empties the history (no clearing pass) and loads register defaults.
`default_nettype none
module windowed_pose_velocity_tracker #(
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata: pos_x[31:0] pos_y[63:32] pos_z[95:64] time_us[143:96]
   //            clear_count[150:144] clear_all[151]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [151:0] req_tdata,
   // req_tuser: operation[0]
   input  wire logic         req_tuser,
   // rsp_tdata: vel_x[31:0] vel_y[63:32] vel_z[95:64] speed[127:96]
   //            entry_count[134:128] cur_x[166:135] cur_y[198:167]
   //            cur_z[230:199] zero[231]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [231:0]      rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [23:0]  csr_data
);
   import wpvt_pkg::*;

   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LATCH = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_VEL   = 7'b0001000,
      S_SQ    = 7'b0010000,
      S_ROOT  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [6:0]    max_hist_ff, max_hist_in;
   logic [23:0]   window_ff, window_in;
   logic [CW-1:0] held_ff, held_in;
   logic          clr_err_ff, clr_err_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          found_ff, found_in;
   logic          vstart_ff, vstart_in;
   logic          rstart_ff, rstart_in;
   logic [1:0]    sq_k_ff, sq_k_in;
   logic [63:0]   sq_ff, sq_in;
   logic [63:0]   acc_ff, acc_in;
   logic [1:0]    status_ff, status_in;
   logic          vel_ok_ff, vel_ok_in;
   pose_type      b_ff, b_in;
   pose_type      a_ff, a_in;
   logic [47:0]   span_ff, span_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [231:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   pose_type      cell_q [HISTORY_DEPTH];
   pose_type      new_pose;
   cell_ctrl_type cell_ctrl;

   logic          accept;
   logic [LW-1:0] max_l, limit, held_l, clear_n;
   logic [48:0]   elapsed;
   logic          qualify;
   logic          lane_done [3];
   logic signed [31:0] lane_vel [3];
   logic [31:0]   sq_mag;
   logic [31:0]   speed;
   logic          root_done;
   logic [31:0]   cur_x, cur_y, cur_z;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign new_pose.x = req_tdata[31:0];
   assign new_pose.y = req_tdata[63:32];
   assign new_pose.z = req_tdata[95:64];
   assign new_pose.t = req_tdata[143:96];

   // Effective history limit, clamped to [2, HISTORY_DEPTH]
   assign max_l   = LW'(max_hist_ff);
   assign limit   = (max_l < LW'(2)) ? LW'(2) :
                    (max_l > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : max_l;
   assign held_l  = LW'(held_ff);
   assign clear_n = req_tdata[151] ? held_l : LW'(req_tdata[150:144]);

   // History chain, closed into a ring for the search rotation
   assign cell_ctrl.push   = accept && (req_tuser == OP_PUSH);
   assign cell_ctrl.rotate = (state_ff == S_SCAN);

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      wpvt_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .newer_in ((i == 0) ? new_pose : cell_q[(i + HISTORY_DEPTH - 1) % HISTORY_DEPTH]),
         .older_in (cell_q[(i + 1) % HISTORY_DEPTH]),
         .pose_out (cell_q[i])
      );
   end

   // Signed span from the entry in cell 1 to the newest entry
   assign elapsed = {1'b0, b_ff.t} - {1'b0, cell_q[1].t};
   assign qualify = (scan_ff < held_ff) && !found_ff && !elapsed[48] &&
                    (elapsed >= 49'((window_ff == 24'd0) ? 24'd1 : window_ff));

   // Three divider lanes, one per axis
   wpvt_vel_lane u_lane_x (
      .clock (clock), .reset (reset), .start (vstart_ff),
      .diff  (33'({b_ff.x[31], b_ff.x} - {a_ff.x[31], a_ff.x})),
      .span  (span_ff), .vel (lane_vel[0]), .done (lane_done[0])
   );
   wpvt_vel_lane u_lane_y (
      .clock (clock), .reset (reset), .start (vstart_ff),
      .diff  (33'({b_ff.y[31], b_ff.y} - {a_ff.y[31], a_ff.y})),
      .span  (span_ff), .vel (lane_vel[1]), .done (lane_done[1])
   );
   wpvt_vel_lane u_lane_z (
      .clock (clock), .reset (reset), .start (vstart_ff),
      .diff  (33'({b_ff.z[31], b_ff.z} - {a_ff.z[31], a_ff.z})),
      .span  (span_ff), .vel (lane_vel[2]), .done (lane_done[2])
   );

   // Magnitude of the component being squared
   always_comb begin
      unique case (sq_k_ff)
         2'd0:    sq_mag = lane_vel[0][31] ? 32'(-lane_vel[0]) : lane_vel[0];
         2'd1:    sq_mag = lane_vel[1][31] ? 32'(-lane_vel[1]) : lane_vel[1];
         default: sq_mag = lane_vel[2][31] ? 32'(-lane_vel[2]) : lane_vel[2];
      endcase
   end

   wpvt_isqrt u_isqrt (
      .clock (clock), .reset (reset), .start (rstart_ff),
      .value (acc_ff), .root (speed), .done (root_done)
   );

   assign cur_x = (held_ff == '0) ? 32'd0 : b_ff.x;
   assign cur_y = (held_ff == '0) ? 32'd0 : b_ff.y;
   assign cur_z = (held_ff == '0) ? 32'd0 : b_ff.z;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      max_hist_in  = max_hist_ff;
      window_in    = window_ff;
      held_in      = held_ff;
      clr_err_in   = clr_err_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      vstart_in    = 1'b0;
      rstart_in    = 1'b0;
      sq_k_in      = sq_k_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      vel_ok_in    = vel_ok_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      span_in      = span_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_HISTORY: max_hist_in = csr_data[6:0];
            REG_WINDOW_US:   window_in   = csr_data;
            default:         window_in   = window_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               clr_err_in = 1'b0;
               if (req_tuser == OP_PUSH) begin
                  if (held_l < limit) begin
                     held_in = held_ff + 1'b1;
                  end
               end else if (clear_n > held_l) begin
                  clr_err_in = 1'b1;
               end else begin
                  held_in = CW'(held_l - clear_n);
               end
               state_in = S_LATCH;
            end
         end
         S_LATCH: begin
            b_in      = cell_q[0];
            vel_ok_in = 1'b0;
            found_in  = 1'b0;
            scan_in   = CW'(1);
            if (clr_err_ff) begin
               status_in = ST_CLEAR;
               state_in  = S_DONE;
            end else if (held_ff == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (qualify) begin
               found_in = 1'b1;
               a_in     = cell_q[1];
               span_in  = elapsed[47:0];
            end
            if (scan_ff == CW'(HISTORY_DEPTH)) begin
               if (found_ff || qualify) begin
                  vstart_in = 1'b1;
                  state_in  = S_VEL;
               end else begin
                  status_in = ST_SPAN;
                  state_in  = S_DONE;
               end
            end
         end
         S_VEL: begin
            if (!vstart_ff && lane_done[0] && lane_done[1] && lane_done[2]) begin
               sq_k_in  = 2'd0;
               acc_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_in   = sq_mag * sq_mag;
            sq_k_in = sq_k_ff + 1'b1;
            if (sq_k_ff != 2'd0) begin
               acc_in = acc_ff + sq_ff;
            end
            if (sq_k_ff == 2'd3) begin
               rstart_in = 1'b1;
               state_in  = S_ROOT;
            end
         end
         S_ROOT: begin
            if (!rstart_ff && root_done) begin
               status_in = ST_OK;
               vel_ok_in = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {1'b0, cur_z, cur_y, cur_x, 7'(held_ff),
                               vel_ok_ff ? {speed, lane_vel[2], lane_vel[1], lane_vel[0]}
                                         : 128'd0};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_hist_ff  <= MAX_HISTORY_RESET;
         window_ff    <= WINDOW_US_RESET;
         held_ff      <= '0;
         clr_err_ff   <= 1'b0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         vstart_ff    <= 1'b0;
         rstart_ff    <= 1'b0;
         sq_k_ff      <= '0;
         status_ff    <= ST_OK;
         vel_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_hist_ff  <= max_hist_in;
         window_ff    <= window_in;
         held_ff      <= held_in;
         clr_err_ff   <= clr_err_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         vstart_ff    <= vstart_in;
         rstart_ff    <= rstart_in;
         sq_k_ff      <= sq_k_in;
         status_ff    <= status_in;
         vel_ok_ff    <= vel_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      b_ff        <= b_in;
      a_ff        <= a_in;
      span_ff     <= span_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

/* rtl/core/wpvt_checker.sv */
// Port-level checks for the windowed pose velocity tracker, bound to the top level.
`default_nettype none
module wpvt_checker #(
   parameter int HISTORY_DEPTH = 64
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [231:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);
   import wpvt_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // One item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in flight");

   // Velocity and speed are zero unless status is ok
   a_vel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[127:0] == 128'd0))
      else $error("nonzero velocity with error status");

   // Empty history reports zero count and zero position
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |->
         (rsp_tdata[134:128] == 7'd0) && (rsp_tdata[230:135] == 96'd0))
      else $error("empty status with nonzero count or position");

   // Count never exceeds the history depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[134:128]) <= HISTORY_DEPTH))
      else $error("entry count above history depth");
endmodule

bind windowed_pose_velocity_tracker wpvt_checker #(
   .HISTORY_DEPTH (HISTORY_DEPTH)
) u_wpvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
